@@ src/rpn_pkg.sv @@
package rpn_pkg;

	localparam int unsigned StackDepthDefault = 256;
	localparam int unsigned DataW = 32;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_SUB   = 5'd1,
		OP_MUL   = 5'd2,
		OP_DIV   = 5'd3,
		OP_MOD   = 5'd4,
		OP_NEG   = 5'd5,
		OP_OR    = 5'd6,
		OP_AND   = 5'd7,
		OP_XOR   = 5'd8,
		OP_NOT   = 5'd9,
		OP_LAND  = 5'd10,
		OP_LOR   = 5'd11,
		OP_LNOT  = 5'd12,
		OP_EQ    = 5'd13,
		OP_NE    = 5'd14,
		OP_GT    = 5'd15,
		OP_LT    = 5'd16,
		OP_GE    = 5'd17,
		OP_LE    = 5'd18,
		OP_SHL   = 5'd19,
		OP_SHR   = 5'd20,
		OP_HRAM  = 5'd21,
		OP_CONST = 5'd22,
		OP_SYM   = 5'd23,
		OP_BANK  = 5'd24
	} opcode_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_HRAM      = 3'd2;
	localparam logic [2:0] ST_DIV_ZERO  = 3'd3;
	localparam logic [2:0] ST_UNDERFLOW = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_WORD = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_B,
		S_RD_A,
		S_WAIT,
		S_EXEC,
		S_DIV,
		S_FIN_RD,
		S_FIN,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // take input beat
		logic rd_b;      // pop into b
		logic rd_a;      // pop into a
		logic div_start;
		logic div_step;
		logic exec;      // compute and push result
		logic fin_rd;    // pop final value
		logic fin;       // range check, load output
		logic clear;     // reset expression state
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pops2;
		logic pops1;
		logic is_div;
		logic div_done;
		logic last;
	} stat_t;

endpackage

@@ src/rpn_if.sv @@
interface rpn_in_if;
	import rpn_pkg::*;
	logic              valid;
	logic              ready;
	logic [4:0]        opcode;
	logic signed [31:0] operand;
	logic              symbol_has_bank;
	logic [1:0]        patch_kind;
	logic              last;
	modport source (output valid, opcode, operand, symbol_has_bank, patch_kind, last,
		input ready);
	modport sink (input valid, opcode, operand, symbol_has_bank, patch_kind, last,
		output ready);
endinterface

interface rpn_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] patch_value;
	logic        relocatable;
	logic [2:0]  status;
	modport source (output valid, patch_value, relocatable, status, input ready);
	modport sink (input valid, patch_value, relocatable, status, output ready);
endinterface

@@ src/rpn_ctrl.sv @@
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// sequence one operation; the final pop and check follow on the last beat
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_RD_B;
				end
			end
			S_RD_B: begin
				if (stat.pops2 || stat.pops1) begin
					cmd.rd_b = 1'b1;
					state_d = stat.pops2 ? S_RD_A : S_WAIT;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d = S_WAIT;
			end
			// let the last popped word settle into its operand register
			S_WAIT: begin
				if (stat.is_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = stat.last ? S_FIN_RD : S_IDLE;
			end
			S_FIN_RD: begin
				cmd.fin_rd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.clear = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ src/rpn_div.sv @@
module rpn_div
	import rpn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  logic [DataW-1:0] a,
	input  logic [DataW-1:0] b,
	output logic             done,
	output logic [DataW-1:0] quot,
	output logic [DataW-1:0] rem
);

	logic [DataW-1:0] q_q, r_q, d_q;
	logic [5:0]       cnt_q;
	logic             nq_q, nr_q;
	logic [DataW:0]   trial;
	logic [DataW-1:0] r_sh;

	// restoring divide on magnitudes, one quotient bit a cycle
	assign r_sh  = {r_q[DataW-2:0], q_q[DataW-1]};
	assign trial = {1'b0, r_sh} - {1'b0, d_q};
	assign done  = (cnt_q == 6'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= 6'(DataW);
		else if (step && !done) cnt_q <= cnt_q - 6'd1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= a[DataW-1] ? (~a + 1'b1) : a;
			d_q  <= b[DataW-1] ? (~b + 1'b1) : b;
			r_q  <= '0;
			nq_q <= a[DataW-1] ^ b[DataW-1];
			nr_q <= a[DataW-1];
		end else if (step && !done) begin
			if (!trial[DataW]) begin
				r_q <= trial[DataW-1:0];
				q_q <= {q_q[DataW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[DataW-2:0], 1'b0};
			end
		end
	end

	// restore signs: truncating division, remainder takes the dividend sign
	assign quot = nq_q ? (~q_q + 1'b1) : q_q;
	assign rem  = nr_q ? (~r_q + 1'b1) : r_q;

endmodule

@@ src/rpn_dp.sv @@
module rpn_dp
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [4:0]  in_opcode,
	input  logic [31:0] in_operand,
	input  logic        in_has_bank,
	input  logic [1:0]  in_kind,
	input  logic        in_last,
	output logic [31:0] patch_value,
	output logic        relocatable,
	output logic [2:0]  status
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

	logic [DataW-1:0] mem [STACK_DEPTH];
	logic [DataW-1:0] rdata;
	logic [SPW-1:0]   sp_q;
	logic [AW-1:0]    rd_addr;
	logic             empty;
	logic             full;

	logic [4:0]       op_q;
	logic [31:0]      operand_q;
	logic             bank_q;
	logic [1:0]       kind_q;
	logic             last_q;
	logic             reloc_q;
	logic [2:0]       err_q;
	logic [2:0]       err_d;
	logic [DataW-1:0] a_q, b_q;
	logic             pend_b_q, pend_a_q;
	logic             uf_b_q, uf_a_q, uf_f_q;
	logic [DataW-1:0] val_b, val_a, fin_v;

	logic [DataW-1:0] res;
	logic             do_push;
	logic             hram_bad;
	logic             div_done;
	logic [DataW-1:0] quot, rem;
	logic signed [DataW-1:0] sa, sb;
	logic [DataW-1:0] mask_v;
	logic             range_bad;
	logic             pops2, pops1;

	assign empty   = (sp_q == '0);
	assign full    = (sp_q == SPW'(STACK_DEPTH));
	assign rd_addr = AW'(sp_q - SPW'(1));

	// registered stack read
	always_ff @(posedge clk) begin
		rdata <= mem[rd_addr];
		if (cmd.exec && do_push && !full) mem[sp_q[AW-1:0]] <= res;
	end

	// popped values land in the cycle after the pop; an empty pop yields zero
	assign val_b = pend_b_q ? (uf_b_q ? '0 : rdata) : b_q;
	assign val_a = pend_a_q ? (uf_a_q ? '0 : rdata) : a_q;
	assign fin_v = uf_f_q ? '0 : rdata;

	always_comb begin
		pops2 = 1'b0;
		pops1 = 1'b0;
		unique case (op_q)
			OP_NEG, OP_NOT, OP_LNOT, OP_HRAM: pops1 = 1'b1;
			OP_CONST, OP_SYM, OP_BANK: ;
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR, OP_LAND,
			OP_LOR, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE, OP_SHL, OP_SHR:
				pops2 = 1'b1;
			default: ;
		endcase
	end

	assign stat.pops2    = pops2;
	assign stat.pops1    = pops1;
	assign stat.is_div   = (op_q == OP_DIV) || (op_q == OP_MOD);
	assign stat.div_done = div_done;
	assign stat.last     = last_q;

	rpn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.step   (cmd.div_step),
		.a      (val_a),
		.b      (val_b),
		.done   (div_done),
		.quot   (quot),
		.rem    (rem)
	);

	assign sa = a_q;
	assign sb = b_q;
	assign hram_bad = (a_q > 32'hFFFF) || ((a_q > 32'hFF) && (a_q < 32'hFF00));

	// operation result; a and b are settled by the time of exec
	always_comb begin
		res = '0;
		do_push = 1'b1;
		unique case (op_q)
			OP_ADD:  res = a_q + b_q;
			OP_SUB:  res = a_q - b_q;
			OP_MUL:  res = a_q * b_q;
			OP_DIV:  res = (b_q == '0) ? '0 : quot;
			OP_MOD:  res = (b_q == '0) ? '0 : rem;
			OP_NEG:  res = '0 - a_q;
			OP_OR:   res = a_q | b_q;
			OP_AND:  res = a_q & b_q;
			OP_XOR:  res = a_q ^ b_q;
			OP_NOT:  res = ~a_q;
			OP_LAND: res = 32'((a_q != '0) && (b_q != '0));
			OP_LOR:  res = 32'((a_q != '0) || (b_q != '0));
			OP_LNOT: res = 32'(a_q == '0);
			OP_EQ:   res = 32'(a_q == b_q);
			OP_NE:   res = 32'(a_q != b_q);
			OP_GT:   res = 32'(sa > sb);
			OP_LT:   res = 32'(sa < sb);
			OP_GE:   res = 32'(sa >= sb);
			OP_LE:   res = 32'(sa <= sb);
			OP_SHL:  res = (b_q > 32'd31) ? '0 : (a_q << b_q[4:0]);
			OP_SHR:  res = (b_q > 32'd31) ? {DataW{a_q[DataW-1]}} : 32'(sa >>> b_q[4:0]);
			OP_HRAM: res = {24'd0, a_q[7:0]};
			OP_CONST, OP_SYM, OP_BANK: res = operand_q;
			default: do_push = 1'b0;
		endcase
	end

	// range check on the final value; long and the spare kind pass unchecked
	always_comb begin
		mask_v = fin_v;
		range_bad = 1'b0;
		if (kind_q == KIND_BYTE) begin
			mask_v = {24'd0, fin_v[7:0]};
			range_bad = ($signed(fin_v) < -32'sd128) || ($signed(fin_v) > 32'sd255);
		end else if (kind_q == KIND_WORD) begin
			mask_v = {16'd0, fin_v[15:0]};
			range_bad = ($signed(fin_v) < -32'sd32768) || ($signed(fin_v) > 32'sd65535);
		end
	end

	// collect the first error of the expression
	always_comb begin
		err_d = err_q;
		if (err_d == ST_OK && pend_b_q && uf_b_q) err_d = ST_UNDERFLOW;
		if (err_d == ST_OK && pend_a_q && uf_a_q) err_d = ST_UNDERFLOW;
		if (cmd.exec) begin
			if (err_d == ST_OK && stat.is_div && b_q == '0) err_d = ST_DIV_ZERO;
			if (err_d == ST_OK && do_push && full) err_d = ST_OVERFLOW;
			if (err_d == ST_OK && op_q == OP_HRAM && hram_bad) err_d = ST_HRAM;
		end
		if (cmd.fin) begin
			if (err_d == ST_OK && uf_f_q) err_d = ST_UNDERFLOW;
			if (err_d == ST_OK && range_bad) err_d = ST_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			reloc_q  <= 1'b0;
			err_q    <= ST_OK;
			pend_b_q <= 1'b0;
			pend_a_q <= 1'b0;
			uf_b_q   <= 1'b0;
			uf_a_q   <= 1'b0;
			uf_f_q   <= 1'b0;
		end else begin
			pend_b_q <= cmd.rd_b;
			pend_a_q <= cmd.rd_a;
			err_q    <= err_d;
			if (cmd.rd_b) uf_b_q <= empty;
			if (cmd.rd_a) uf_a_q <= empty;
			if (cmd.fin_rd) uf_f_q <= empty;
			if (cmd.clear) begin
				sp_q    <= '0;
				reloc_q <= 1'b0;
				err_q   <= ST_OK;
			end else begin
				if ((cmd.rd_b || cmd.rd_a || cmd.fin_rd) && !empty) sp_q <= sp_q - SPW'(1);
				if (cmd.exec && do_push && !full) sp_q <= sp_q + SPW'(1);
				if (cmd.exec && op_q == OP_SYM && bank_q) reloc_q <= 1'b1;
			end
		end
	end

	// operand registers and output hold; single-operand ops keep their operand in a
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= in_opcode;
			operand_q <= in_operand;
			bank_q    <= in_has_bank;
			kind_q    <= in_kind;
			last_q    <= in_last;
			a_q       <= '0;
			b_q       <= '0;
		end
		if (pend_b_q) b_q <= val_b;
		if (pend_a_q) a_q <= val_a;
		if (pend_b_q && !pops2) a_q <= val_b;
		if (cmd.fin) begin
			patch_value <= (err_d == ST_OK) ? mask_v : '0;
			relocatable <= reloc_q;
			status      <= err_d;
		end
	end

endmodule

@@ src/rpn_expression_stack_evaluator_unit.sv @@
// RPN expression evaluator. One operation is taken per input beat and run on
// a one-read, one-write operand stack of STACK_DEPTH 32-bit entries; each pop
// costs a registered memory read, so a one-operand operation adds a pop and a
// wait state to a push and a two-operand one two pops and the wait, while div
// and mod also run a bit-serial divider. On a beat marked last the final value
// is popped and checked against the patch kind and one result beat carries the
// masked value, the relocation flag and the first error of the expression; the
// next beat is taken once that result has gone. Stack contents need no reset.
module rpn_expression_stack_evaluator_unit
	import rpn_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = StackDepthDefault
) (
	input  logic  clk,
	input  logic  arst_n,
	rpn_in_if.sink    in_ch,
	rpn_out_if.source out_ch
);

	cmd_t  cmd;
	stat_t stat;

	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rpn_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_opcode   (in_ch.opcode),
		.in_operand  (in_ch.operand),
		.in_has_bank (in_ch.symbol_has_bank),
		.in_kind     (in_ch.patch_kind),
		.in_last     (in_ch.last),
		.patch_value (out_ch.patch_value),
		.relocatable (out_ch.relocatable),
		.status      (out_ch.status)
	);

endmodule
